[rtl/fcsg_pkg.sv]
`default_nettype none

package fcsg_pkg;

    localparam int IN_W             = 72;
    localparam int POS_W            = 19;
    localparam int EXT_W            = 16;
    localparam int SQ_OP_W          = 15;
    localparam int SQR_W            = 2 * SQ_OP_W;
    localparam int SQRT_W           = SQR_W + 1;
    localparam int ROOT_TOP         = SQR_W - 2;
    localparam int CENTRE_OUT_R_MAX = 128;
    localparam int DY_W             = 8;
    localparam int SQ_W             = 15;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_BOUND,
        ST_INIT,
        ST_SHRINK,
        ST_EMIT_POS,
        ST_EMIT_NEG,
        ST_NEXT_DY,
        ST_SCAN_ROW,
        ST_SQRT_LOAD,
        ST_SQRT_STEP,
        ST_EMIT_SCAN,
        ST_FINISH
    } fcsg_state_t;

    typedef enum logic [1:0] {
        ROW_POS,
        ROW_NEG,
        ROW_SCAN
    } row_sel_t;

    typedef struct packed {
        logic     load;
        logic     rotate;
        logic     square_r;
        logic     init;
        logic     shrink;
        logic     emit;
        row_sel_t emit_sel;
        logic     dy_next;
        logic     y_next;
        logic     square_dy;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     flush;
    } fcsg_cmd_t;

    typedef struct packed {
        logic r_neg;
        logic off_screen;
        logic r_small;
        logic shrink_req;
        logic dy_zero;
        logic dy_last;
        logic y_end;
        logic row_out;
        logic sqrt_done;
        logic emit_stall;
    } fcsg_status_t;

endpackage

`default_nettype wire

[rtl/fcsg_ctrl.sv]
`default_nettype none

module fcsg_ctrl
    import fcsg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire fcsg_status_t st,
    output fcsg_cmd_t         cmd
);

    fcsg_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
                state_next = st.r_neg ? ST_FINISH : ST_BOUND;
            end
            ST_BOUND:
            begin
                cmd.square_r = 1'b1;
                state_next   = st.off_screen ? ST_FINISH : ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = st.r_small ? ST_SHRINK : ST_SCAN_ROW;
            end
            ST_SHRINK:
            begin
                if (st.shrink_req)
                begin
                    cmd.shrink = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT_POS;
                end
            end
            ST_EMIT_POS:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = ROW_POS;
                if (!st.emit_stall)
                begin
                    state_next = st.dy_zero ? ST_NEXT_DY : ST_EMIT_NEG;
                end
            end
            ST_EMIT_NEG:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = ROW_NEG;
                if (!st.emit_stall)
                begin
                    state_next = ST_NEXT_DY;
                end
            end
            ST_NEXT_DY:
            begin
                if (st.dy_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.dy_next = 1'b1;
                    state_next  = ST_SHRINK;
                end
            end
            ST_SCAN_ROW:
            begin
                if (st.y_end)
                begin
                    state_next = ST_FINISH;
                end
                else if (st.row_out)
                begin
                    cmd.y_next = 1'b1;
                end
                else
                begin
                    cmd.square_dy = 1'b1;
                    state_next    = ST_SQRT_LOAD;
                end
            end
            ST_SQRT_LOAD:
            begin
                cmd.sqrt_load = 1'b1;
                state_next    = ST_SQRT_STEP;
            end
            ST_SQRT_STEP:
            begin
                cmd.sqrt_step = 1'b1;
                if (st.sqrt_done)
                begin
                    state_next = ST_EMIT_SCAN;
                end
            end
            ST_EMIT_SCAN:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = ROW_SCAN;
                if (!st.emit_stall)
                begin
                    cmd.y_next = 1'b1;
                    state_next = ST_SCAN_ROW;
                end
            end
            ST_FINISH:
            begin
                cmd.flush = 1'b1;
                if (!st.emit_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/fcsg_datapath.sv]
`default_nettype none

module fcsg_datapath
    import fcsg_pkg::*;
#(
    parameter int SCREEN_SIZE = 64,
    localparam int CW         = $clog2(SCREEN_SIZE),
    localparam int OUT_W      = ((3 * CW + 25 + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_wr_data,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire fcsg_cmd_t        cmd,
    output fcsg_status_t          st,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    localparam logic signed [POS_W-1:0] SCR    = POS_W'(SCREEN_SIZE);
    localparam logic signed [POS_W-1:0] SCR_M1 = POS_W'(SCREEN_SIZE - 1);
    localparam logic [SQRT_W-1:0]       BIT_INIT = SQRT_W'(1) << ROOT_TOP;

    logic [1:0]                rot_reg, rot_next;
    logic signed [15:0]        cx_reg, cx_next, cy_reg, cy_next, r_reg, r_next;
    logic [7:0]                red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic signed [POS_W-1:0]   pcx_reg, pcx_next, pcy_reg, pcy_next;
    logic [SQR_W-1:0]          prod_reg, prod_next, r2_reg, r2_next, n_reg, n_next;
    logic [EXT_W-1:0]          ext_reg, ext_next;
    logic [SQ_W-1:0]           esq_reg, esq_next, dysq_reg, dysq_next;
    logic [DY_W-1:0]           dy_reg, dy_next;
    logic [CW:0]               y_reg, y_next;
    logic [SQRT_W-1:0]         res_reg, res_next, bit_reg, bit_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [CW-1:0]             pend_row_reg, pend_row_next, pend_start_reg, pend_start_next;
    logic [CW:0]               pend_end_reg, pend_end_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_last_reg, out_last_next;
    logic [CW-1:0]             out_row_reg, out_row_next, out_start_reg, out_start_next;
    logic [CW:0]               out_end_reg, out_end_next;
    logic [7:0]                out_red_reg, out_red_next;
    logic [7:0]                out_green_reg, out_green_next;
    logic [7:0]                out_blue_reg, out_blue_next;

    logic signed [POS_W-1:0]   cx_ext, cy_ext, r_ext, rot_x, rot_y;
    logic signed [POS_W-1:0]   dy_scan, row_y, ext_pos, x0, x1, span_a, span_b;
    logic [POS_W-1:0]          absdy;
    logic [EXT_W-1:0]          ext_sel;
    logic [SQ_OP_W-1:0]        sq_op;
    logic [SQR_W-1:0]          sq_prod;
    logic [SQRT_W-1:0]         trial;
    logic                      take, span_vis, out_free, emit_stall, load_out, load_last;

    assign cx_ext = POS_W'(cx_reg);
    assign cy_ext = POS_W'(cy_reg);
    assign r_ext  = POS_W'(r_reg);

    always_comb
    begin
        unique case (rot_reg)
            ROT_0:
            begin
                rot_x = cx_ext;
                rot_y = cy_ext;
            end
            ROT_90:
            begin
                rot_x = SCR_M1 - cy_ext;
                rot_y = cx_ext;
            end
            ROT_180:
            begin
                rot_x = SCR_M1 - cx_ext;
                rot_y = SCR_M1 - cy_ext;
            end
            ROT_270:
            begin
                rot_x = cy_ext;
                rot_y = SCR_M1 - cx_ext;
            end
            default:
            begin
                rot_x = cx_ext;
                rot_y = cy_ext;
            end
        endcase
    end

    // scan row offset and squarer shared by r squared and dy squared
    assign dy_scan = $signed(POS_W'(y_reg)) - pcy_reg;
    assign absdy   = dy_scan[POS_W-1] ? unsigned'(-dy_scan) : unsigned'(dy_scan);
    assign sq_op   = cmd.square_dy ? absdy[SQ_OP_W-1:0] : r_reg[SQ_OP_W-1:0];
    assign sq_prod = SQR_W'(sq_op) * SQR_W'(sq_op);

    // one bit of the root per step
    assign trial = res_reg + bit_reg;
    assign take  = SQRT_W'(n_reg) >= trial;

    always_comb
    begin
        case (cmd.emit_sel)
            ROW_POS:
            begin
                row_y   = pcy_reg + $signed(POS_W'(dy_reg));
                ext_sel = ext_reg;
            end
            ROW_NEG:
            begin
                row_y   = pcy_reg - $signed(POS_W'(dy_reg));
                ext_sel = ext_reg;
            end
            ROW_SCAN:
            begin
                row_y   = $signed(POS_W'(y_reg));
                ext_sel = res_reg[EXT_W-1:0];
            end
            default:
            begin
                row_y   = pcy_reg;
                ext_sel = ext_reg;
            end
        endcase
    end

    assign ext_pos  = $signed(POS_W'(ext_sel));
    assign x0       = pcx_reg - ext_pos;
    assign x1       = pcx_reg + ext_pos + POS_W'(1);
    assign span_vis = (row_y >= 0) && (row_y < SCR) && (x1 > 0) && (x0 < SCR);
    assign span_a   = (x0 < 0) ? '0 : x0;
    assign span_b   = (x1 > SCR) ? SCR : x1;

    assign out_free   = !out_valid_reg || m_tready;
    assign emit_stall = ((cmd.emit && span_vis) || cmd.flush) && pend_valid_reg && !out_free;

    always_comb
    begin
        st.r_neg      = r_reg[15];
        st.off_screen = (pcx_reg + r_ext < 0) || (pcx_reg - r_ext >= SCR) ||
                        (pcy_reg + r_ext < 0) || (pcy_reg - r_ext >= SCR);
        st.r_small    = r_reg <= 16'(CENTRE_OUT_R_MAX);
        st.shrink_req = (ext_reg != '0) &&
                        ((SQR_W'(esq_reg) + SQR_W'(dysq_reg)) > r2_reg);
        st.dy_zero    = dy_reg == '0;
        st.dy_last    = EXT_W'(dy_reg) == unsigned'(r_reg);
        st.y_end      = y_reg == (CW+1)'(SCREEN_SIZE);
        st.row_out    = absdy > unsigned'(r_ext);
        st.sqrt_done  = bit_reg[0];
        st.emit_stall = emit_stall;
    end

    always_comb
    begin
        rot_next        = cfg_wr_en ? cfg_wr_data : rot_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        r_next          = r_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        pcx_next        = pcx_reg;
        pcy_next        = pcy_reg;
        prod_next       = prod_reg;
        r2_next         = r2_reg;
        n_next          = n_reg;
        ext_next        = ext_reg;
        esq_next        = esq_reg;
        dysq_next       = dysq_reg;
        dy_next         = dy_reg;
        y_next          = y_reg;
        res_next        = res_reg;
        bit_next        = bit_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_last_next   = out_last_reg;
        out_row_next    = out_row_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_red_next    = out_red_reg;
        out_green_next  = out_green_reg;
        out_blue_next   = out_blue_reg;
        load_out        = 1'b0;
        load_last       = 1'b0;

        if (cmd.load)
        begin
            cx_next    = s_tdata[15:0];
            cy_next    = s_tdata[31:16];
            r_next     = s_tdata[47:32];
            red_next   = s_tdata[55:48];
            green_next = s_tdata[63:56];
            blue_next  = s_tdata[71:64];
        end
        if (cmd.rotate)
        begin
            pcx_next = rot_x;
            pcy_next = rot_y;
        end
        if (cmd.square_r || cmd.square_dy)
        begin
            prod_next = sq_prod;
        end
        if (cmd.init)
        begin
            r2_next   = prod_reg;
            ext_next  = unsigned'(r_reg);
            esq_next  = prod_reg[SQ_W-1:0];
            dy_next   = '0;
            dysq_next = '0;
            y_next    = '0;
        end
        if (cmd.shrink)
        begin
            ext_next = ext_reg - EXT_W'(1);
            esq_next = esq_reg - SQ_W'({ext_reg, 1'b0}) + SQ_W'(1);
        end
        if (cmd.dy_next)
        begin
            dy_next   = dy_reg + DY_W'(1);
            dysq_next = dysq_reg + SQ_W'({dy_reg, 1'b0}) + SQ_W'(1);
        end
        if (cmd.y_next)
        begin
            y_next = y_reg + (CW+1)'(1);
        end
        if (cmd.sqrt_load)
        begin
            n_next   = r2_reg - prod_reg;
            res_next = '0;
            bit_next = BIT_INIT;
        end
        if (cmd.sqrt_step)
        begin
            if (take)
            begin
                n_next   = n_reg - trial[SQR_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end

        // one span held back so the final one can carry last
        if (cmd.emit && span_vis && !emit_stall)
        begin
            if (pend_valid_reg)
            begin
                load_out = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_row_next   = row_y[CW-1:0];
            pend_start_next = span_a[CW-1:0];
            pend_end_next   = span_b[CW:0];
        end
        if (cmd.flush && pend_valid_reg && out_free)
        begin
            load_out        = 1'b1;
            load_last       = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_last_next  = load_last;
            out_row_next   = pend_row_reg;
            out_start_next = pend_start_reg;
            out_end_next   = pend_end_reg;
            out_red_next   = red_reg;
            out_green_next = green_reg;
            out_blue_next  = blue_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg        <= ROT_0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rot_reg        <= rot_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        r_reg          <= r_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        pcx_reg        <= pcx_next;
        pcy_reg        <= pcy_next;
        prod_reg       <= prod_next;
        r2_reg         <= r2_next;
        n_reg          <= n_next;
        ext_reg        <= ext_next;
        esq_reg        <= esq_next;
        dysq_reg       <= dysq_next;
        dy_reg         <= dy_next;
        y_reg          <= y_next;
        res_reg        <= res_next;
        bit_reg        <= bit_next;
        pend_row_reg   <= pend_row_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        out_last_reg   <= out_last_next;
        out_row_reg    <= out_row_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_red_reg    <= out_red_next;
        out_green_reg  <= out_green_next;
        out_blue_reg   <= out_blue_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_blue_reg, out_green_reg, out_red_reg,
                              out_end_reg, out_start_reg, out_row_reg});

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush && !emit_stall |=> !pend_valid_reg)
        else $error("held span not released at end of command");

    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && span_vis && pend_valid_reg && !emit_stall |=> out_valid_reg && !out_last_reg)
        else $error("held span not passed to output");

    a_root_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (cmd.emit_sel == ROW_SCAN) |-> res_reg[SQRT_W-1:EXT_W] == '0)
        else $error("square root result too wide");

    a_small_extent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shrink |-> (ext_reg != '0) && (ext_reg <= EXT_W'(CENTRE_OUT_R_MAX)))
        else $error("extent out of range in centre-out walk");

endmodule

`default_nettype wire

[rtl/filled_circle_span_generator_core.sv]
`default_nettype none

// channel   direction  handshake           payload
// s_        in         s_tvalid/s_tready   s_tdata: circle command
// m_        out        m_tvalid/m_tready   m_tdata: span, m_tlast: last span of command
// cfg_      in         cfg_wr_en           cfg_wr_data: rotation
//
// radius up to 128: walked centre-out, one row offset at a time, shrinking the extent step by step
// larger radius: every row is scanned; rows outside the radius are skipped, rows inside take a 15-step root
// a command also passes through setup states (rotate, bound, init) and a flush state
// reset clears the controller, the held span, the output register and rotation (to 0)
// a stalled output holds the row walk; one span is held back to mark the last one

module filled_circle_span_generator_core
    import fcsg_pkg::*;
#(
    parameter int SCREEN_SIZE = 64,
    localparam int CW         = $clog2(SCREEN_SIZE),
    localparam int OUT_W      = ((3 * CW + 25 + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_wr_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // center_x, center_y, radius, red, green, blue
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // row, span_start, span_end, fill_red, fill_green, fill_blue, zero pad
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    fcsg_cmd_t    cmd;
    fcsg_status_t st;

    fcsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fcsg_datapath #(
        .SCREEN_SIZE (SCREEN_SIZE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
